// File: sv/tkrc_pkg.sv
// tkrc_pkg: widths, micro-op codes, register indexes and shared types for the
// three-knot range correction block. No dependencies.
package tkrc_pkg;

	localparam int FRAC_BITS = 16;
	localparam int KM_SCALE  = 1000;

	localparam int KM_W     = 8;
	localparam int PAIR_W   = 32;
	localparam int CORR_W   = 16;
	localparam int RANGE_W  = 18;
	localparam int SECOND_W = 16;
	localparam int CFG_IDX_W = 3;

	localparam int RC_W = 16;
	localparam int SC_W = 16;
	localparam int CR_W = 20;
	localparam int CS_W = 17;

	// knot distance in metres, signed
	localparam int KMM_W = 18;
	localparam int D_W   = 20;
	localparam int MAG_W = D_W - 1;
	// quotient magnitude and signed fraction
	localparam int Q_W   = MAG_W + FRAC_BITS;
	localparam int T_W   = Q_W + 1;
	localparam int DIFF_W = CORR_W + 1;
	localparam int PROD_W = T_W + DIFF_W;
	localparam int P_W    = PROD_W + 1;
	localparam int STATE_W = 40;
	localparam int SUM_W  = (((RANGE_W + 1 + FRAC_BITS) > STATE_W) ?
		(RANGE_W + 1 + FRAC_BITS) : STATE_W) + 2;
	localparam int CNT_W  = $clog2(Q_W + 1);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_REF_KM_1    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REF_KM_2    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REF_KM_3    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CORR_PAIR_1 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CORR_PAIR_2 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CORR_PAIR_3 = 3'd5;

	// micro-ops
	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] OP_NOP  = 4'd0;
	localparam logic [OP_W-1:0] OP_LOAD = 4'd1;
	localparam logic [OP_W-1:0] OP_KNOT = 4'd2;
	localparam logic [OP_W-1:0] OP_SEL  = 4'd3;
	localparam logic [OP_W-1:0] OP_DIV  = 4'd4;
	localparam logic [OP_W-1:0] OP_FIX  = 4'd5;
	localparam logic [OP_W-1:0] OP_MULR = 4'd6;
	localparam logic [OP_W-1:0] OP_MULS = 4'd7;
	localparam logic [OP_W-1:0] OP_OUT  = 4'd8;

	// jump conditions
	localparam int J_W = 3;
	localparam logic [J_W-1:0] J_NEVER   = 3'd0;
	localparam logic [J_W-1:0] J_NOIN    = 3'd1;
	localparam logic [J_W-1:0] J_HELD    = 3'd2;
	localparam logic [J_W-1:0] J_DIVMORE = 3'd3;
	localparam logic [J_W-1:0] J_OBUSY   = 3'd4;

	localparam int STEP_W = 3;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [J_W-1:0]    jcond;
		logic [STEP_W-1:0] target;
	} uword_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            take;
	} ctl_t;

	typedef struct packed {
		logic held;
		logic div_more;
		logic out_busy;
	} stat_t;

	localparam logic signed [SUM_W-1:0] FRAC_MASK = SUM_W'((64'd1 << FRAC_BITS) - 64'd1);

	// divide by 2^FRAC_BITS, truncating toward zero
	function automatic logic signed [SUM_W-1:0] trunc_frac(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] adj;
		adj = v[SUM_W-1] ? (v + FRAC_MASK) : v;
		return adj >>> FRAC_BITS;
	endfunction

	function automatic logic signed [SUM_W-1:0] clip(input logic signed [SUM_W-1:0] v,
		input logic signed [SUM_W-1:0] lo, input logic signed [SUM_W-1:0] hi);
		logic signed [SUM_W-1:0] r;
		if (v < lo) begin
			r = lo;
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// File: sv/tkrc_seq.sv
// tkrc_seq: step counter and micro-program table of the range correction.
// Depends on tkrc_pkg for the control word, op codes and jump conditions.
module tkrc_seq import tkrc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  stat_t stat,
	output ctl_t  ctl
);

	logic [STEP_W-1:0] step_q;
	uword_t            uw;
	logic              jmp;

	// the counter wraps from the output step back to the wait step
	function automatic uword_t ucode(input logic [STEP_W-1:0] s);
		uword_t w;
		unique case (s)
			3'd0: w = '{op: OP_LOAD, jcond: J_NOIN,    target: 3'd0};
			3'd1: w = '{op: OP_KNOT, jcond: J_NEVER,   target: 3'd0};
			3'd2: w = '{op: OP_SEL,  jcond: J_HELD,    target: 3'd7};
			3'd3: w = '{op: OP_DIV,  jcond: J_DIVMORE, target: 3'd3};
			3'd4: w = '{op: OP_FIX,  jcond: J_NEVER,   target: 3'd0};
			3'd5: w = '{op: OP_MULR, jcond: J_NEVER,   target: 3'd0};
			3'd6: w = '{op: OP_MULS, jcond: J_NEVER,   target: 3'd0};
			3'd7: w = '{op: OP_OUT,  jcond: J_OBUSY,   target: 3'd7};
		endcase
		return w;
	endfunction

	assign uw = ucode(step_q);

	always_comb begin
		unique case (uw.jcond)
			J_NOIN:    jmp = !in_valid;
			J_HELD:    jmp = stat.held;
			J_DIVMORE: jmp = stat.div_more;
			J_OBUSY:   jmp = stat.out_busy;
			default:   jmp = 1'b0;
		endcase
	end

	assign ctl.op   = uw.op;
	assign ctl.take = (uw.op == OP_LOAD) && in_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else begin
			step_q <= jmp ? uw.target : step_q + 1'b1;
		end
	end

endmodule

// File: sv/tkrc_dp.sv
// tkrc_dp: registers, knot distances, serial divider, shared multiplier and
// output register of the range correction. Depends on tkrc_pkg.
module tkrc_dp import tkrc_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ctl_t                        ctl,
	output stat_t                       stat,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_W-1:0]        cfg_idx,
	input  logic [PAIR_W-1:0]           cfg_data,
	input  logic [RANGE_W-1:0]          measured_range,
	input  logic signed [SECOND_W-1:0]  measured_second,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [RC_W-1:0]      range_corr,
	output logic signed [SC_W-1:0]      second_corr,
	output logic signed [CR_W-1:0]      corrected_range,
	output logic signed [CS_W-1:0]      corrected_second,
	output logic                        held
);

	localparam logic [KMM_W-1:0] KM_SCALE_V = KMM_W'(KM_SCALE);
	localparam logic signed [STATE_W-1:0] ST_MAX = {1'b0, {(STATE_W-1){1'b1}}};
	localparam logic signed [STATE_W-1:0] ST_MIN = {1'b1, {(STATE_W-1){1'b0}}};

	logic [KM_W-1:0]   ref_km_q [3];
	logic [PAIR_W-1:0] corr_q   [3];
	logic signed [STATE_W-1:0] last_r_q, last_s_q;
	logic out_valid_q;

	logic [RANGE_W-1:0]         rng_q;
	logic signed [SECOND_W-1:0] sec_q;
	logic signed [D_W-1:0]      d_q [3];
	logic                       seg_q;
	logic                       held_q;
	logic                       neg_q;
	logic [Q_W-1:0]             dvd_q;
	logic [MAG_W-1:0]           rem_q;
	logic [MAG_W-1:0]           den_q;
	logic [CNT_W-1:0]           cnt_q;
	logic signed [T_W-1:0]      t_q;

	// knot distances
	logic signed [D_W-1:0] d_c [3];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			d_c[k] = D_W'($signed({1'b0, KMM_W'(ref_km_q[k]) * KM_SCALE_V}))
				- D_W'($signed(corr_q[k][PAIR_W-1:CORR_W]));
		end
	end

	// segment pick
	logic signed [D_W-1:0] rng_ext, da, db, num, den, num_abs, den_abs;
	logic seg1_ok, seg2_ok;
	assign rng_ext = D_W'($signed({1'b0, rng_q}));
	assign seg1_ok = (rng_ext <= d_q[1]) && (d_q[1] != d_q[0]);
	assign seg2_ok = d_q[2] != d_q[1];
	assign da      = seg1_ok ? d_q[0] : d_q[1];
	assign db      = seg1_ok ? d_q[1] : d_q[2];
	assign num     = rng_ext - da;
	assign den     = db - da;
	assign num_abs = num[D_W-1] ? -num : num;
	assign den_abs = den[D_W-1] ? -den : den;

	// restoring divide step
	logic [MAG_W:0] shifted, sub;
	logic           ge;
	assign shifted = {rem_q, dvd_q[Q_W-1]};
	assign sub     = shifted - {1'b0, den_q};
	assign ge      = shifted >= {1'b0, den_q};

	// shared multiplier for both corrections
	logic [PAIR_W-1:0]       pa, pb;
	logic signed [CORR_W-1:0] ca, cb;
	logic signed [DIFF_W-1:0] cdiff;
	logic signed [PROD_W-1:0] prod;
	logic signed [P_W-1:0]    psum;
	logic signed [STATE_W-1:0] psat;
	assign pa = seg_q ? corr_q[1] : corr_q[0];
	assign pb = seg_q ? corr_q[2] : corr_q[1];
	assign ca = (ctl.op == OP_MULR) ? $signed(pa[PAIR_W-1:CORR_W]) : $signed(pa[CORR_W-1:0]);
	assign cb = (ctl.op == OP_MULR) ? $signed(pb[PAIR_W-1:CORR_W]) : $signed(pb[CORR_W-1:0]);
	assign cdiff = DIFF_W'(cb) - DIFF_W'(ca);
	assign prod  = t_q * cdiff;
	assign psum  = P_W'(prod) + (P_W'(ca) <<< FRAC_BITS);
	always_comb begin
		if (psum > P_W'(ST_MAX)) begin
			psat = ST_MAX;
		end else if (psum < P_W'(ST_MIN)) begin
			psat = ST_MIN;
		end else begin
			psat = psum[STATE_W-1:0];
		end
	end

	// output values
	logic signed [SUM_W-1:0] rc_i, sc_i, cr_i, cs_i;
	assign rc_i = clip(trunc_frac(SUM_W'(last_r_q)), SUM_W'(-32768), SUM_W'(32767));
	assign sc_i = clip(trunc_frac(SUM_W'(last_s_q)), SUM_W'(-32768), SUM_W'(32767));
	assign cr_i = clip(trunc_frac((SUM_W'($signed({1'b0, rng_q})) <<< FRAC_BITS)
		+ SUM_W'(last_r_q)), SUM_W'(-524288), SUM_W'(524287));
	assign cs_i = clip(trunc_frac((SUM_W'(sec_q) <<< FRAC_BITS) + SUM_W'(last_s_q)),
		SUM_W'(-65536), SUM_W'(65535));

	logic out_busy, out_load;
	assign out_busy = out_valid_q && !out_ready;
	assign out_load = (ctl.op == OP_OUT) && !out_busy;

	assign stat.held     = !seg1_ok && !seg2_ok;
	assign stat.div_more = cnt_q != CNT_W'(1);
	assign stat.out_busy = out_busy;
	assign out_valid     = out_valid_q;

	// control state and stored corrections
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				ref_km_q[k] <= '0;
				corr_q[k]   <= '0;
			end
			last_r_q    <= '0;
			last_s_q    <= '0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_REF_KM_1:    ref_km_q[0] <= cfg_data[KM_W-1:0];
					REG_REF_KM_2:    ref_km_q[1] <= cfg_data[KM_W-1:0];
					REG_REF_KM_3:    ref_km_q[2] <= cfg_data[KM_W-1:0];
					REG_CORR_PAIR_1: corr_q[0]   <= cfg_data;
					REG_CORR_PAIR_2: corr_q[1]   <= cfg_data;
					REG_CORR_PAIR_3: corr_q[2]   <= cfg_data;
					default: ;
				endcase
			end
			if (ctl.op == OP_MULR) begin
				last_r_q <= psat;
			end
			if (ctl.op == OP_MULS) begin
				last_s_q <= psat;
			end
			if (ctl.op == OP_SEL) begin
				cnt_q <= CNT_W'(Q_W);
			end else if (ctl.op == OP_DIV) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (ctl.take) begin
			rng_q <= measured_range;
			sec_q <= measured_second;
		end
		if (ctl.op == OP_KNOT) begin
			for (int k = 0; k < 3; k++) begin
				d_q[k] <= d_c[k];
			end
		end
		if (ctl.op == OP_SEL) begin
			seg_q  <= !seg1_ok;
			held_q <= !seg1_ok && !seg2_ok;
			neg_q  <= num[D_W-1] ^ den[D_W-1];
			dvd_q  <= Q_W'(num_abs[MAG_W-1:0]) << FRAC_BITS;
			den_q  <= den_abs[MAG_W-1:0];
			rem_q  <= '0;
		end
		if (ctl.op == OP_DIV) begin
			rem_q <= ge ? sub[MAG_W-1:0] : shifted[MAG_W-1:0];
			dvd_q <= {dvd_q[Q_W-2:0], ge};
		end
		if (ctl.op == OP_FIX) begin
			t_q <= neg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});
		end
		if (out_load) begin
			range_corr       <= rc_i[RC_W-1:0];
			second_corr      <= sc_i[SC_W-1:0];
			corrected_range  <= cr_i[CR_W-1:0];
			corrected_second <= cs_i[CS_W-1:0];
			held             <= held_q;
		end
	end

endmodule

// File: sv/three_knot_range_correction.sv
// three_knot_range_correction: top level, microcoded sequencer and datapath.
// Steps per word: wait/load, knot, select, one divide step per quotient bit
// (35 steps), fix, two multiplies and output; a held word skips from select to output.
// A new word is taken only at the wait step, after the last word's output step.
// Reset: arst_n clears the step counter, divide counter, stored corrections, last corrections and the output valid.
// Depends on tkrc_pkg, tkrc_seq, tkrc_dp.
module three_knot_range_correction import tkrc_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_W-1:0]        cfg_idx,
	input  logic [PAIR_W-1:0]           cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [RANGE_W-1:0]          measured_range,
	input  logic signed [SECOND_W-1:0]  measured_second,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [RC_W-1:0]      range_corr,
	output logic signed [SC_W-1:0]      second_corr,
	output logic signed [CR_W-1:0]      corrected_range,
	output logic signed [CS_W-1:0]      corrected_second,
	output logic                        held
);

	ctl_t  ctl;
	stat_t stat;

	tkrc_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.ctl      (ctl)
	);

	tkrc_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl              (ctl),
		.stat             (stat),
		.cfg_we           (cfg_we),
		.cfg_idx          (cfg_idx),
		.cfg_data         (cfg_data),
		.measured_range   (measured_range),
		.measured_second  (measured_second),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.range_corr       (range_corr),
		.second_corr      (second_corr),
		.corrected_range  (corrected_range),
		.corrected_second (corrected_second),
		.held             (held)
	);

	assign in_ready = ctl.op == OP_LOAD;

	// an accepted word moves the sequencer off the wait step
	a_take_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input still taken after accept");

	// held decision skips straight to the output step
	a_held_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == OP_SEL) && stat.held |=> ctl.op == OP_OUT)
		else $error("held word did not go to output");

	// a loaded result is offered in the next cycle
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == OP_OUT) && !stat.out_busy |=> out_valid)
		else $error("result not offered after load");

endmodule

// File: test/range_fix_checker.sv
// range_fix_checker: follows the config port and both word channels of
// three_knot_range_correction, predicts every result word and compares it.
// Depends on tkrc_pkg.
module range_fix_checker import tkrc_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_idx,
	input  logic [PAIR_W-1:0]          cfg_data,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic [RANGE_W-1:0]         measured_range,
	input  logic signed [SECOND_W-1:0] measured_second,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic signed [RC_W-1:0]     range_corr,
	input  logic signed [SC_W-1:0]     second_corr,
	input  logic signed [CR_W-1:0]     corrected_range,
	input  logic signed [CS_W-1:0]     corrected_second,
	input  logic                       held,
	output int                         mismatches,
	output int                         outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [RC_W-1:0] rc;
		logic [SC_W-1:0] sc;
		logic [CR_W-1:0] cr;
		logic [CS_W-1:0] cs;
		logic            held;
	} fix_word_t;

	localparam longint ONE = longint'(1) << FRAC_BITS;

	logic [KM_W-1:0]           knot_km [3];
	logic [PAIR_W-1:0]         knot_pair [3];
	logic signed [STATE_W-1:0] range_acc;
	logic signed [STATE_W-1:0] second_acc;
	fix_word_t                 due_q [$];

	// clamp to the range of a signed w-bit value
	function automatic longint sat_to(input longint v, input int w);
		longint lim;
		lim = longint'(1) << (w - 1);
		if (v < -lim) begin
			return -lim;
		end else if (v > lim - 1) begin
			return lim - 1;
		end
		return v;
	endfunction

	function automatic longint knot_rcorr(input int k);
		return longint'($signed(knot_pair[k][PAIR_W-1 -: CORR_W]));
	endfunction

	function automatic longint knot_scorr(input int k);
		return longint'($signed(knot_pair[k][CORR_W-1:0]));
	endfunction

	function automatic longint lerp(input longint t, input longint ca, input longint cb);
		return sat_to(t * (cb - ca) + ca * ONE, STATE_W);
	endfunction

	// one word in, one result out; updates the stored corrections unless the word is held
	function automatic fix_word_t correct_word(input logic [RANGE_W-1:0] rng,
		input logic signed [SECOND_W-1:0] sec);
		longint knot_d [3];
		longint r, s, t, rc, sc;
		int k, seg;
		fix_word_t w;
		r = longint'(rng);
		s = longint'(sec);
		for (k = 0; k < 3; k++) begin
			knot_d[k] = longint'(knot_km[k]) * KM_SCALE - knot_rcorr(k);
		end
		seg = -1;
		if (r <= knot_d[1] && knot_d[1] != knot_d[0]) begin
			seg = 0;
		end else if (knot_d[2] != knot_d[1]) begin
			seg = 1;
		end
		w.held = (seg < 0);
		if (seg >= 0) begin
			t = ((r - knot_d[seg]) * ONE) / (knot_d[seg+1] - knot_d[seg]);
			range_acc = STATE_W'(lerp(t, knot_rcorr(seg), knot_rcorr(seg + 1)));
			second_acc = STATE_W'(lerp(t, knot_scorr(seg), knot_scorr(seg + 1)));
		end
		rc = longint'(range_acc);
		sc = longint'(second_acc);
		w.rc = RC_W'(sat_to(rc / ONE, RC_W));
		w.sc = SC_W'(sat_to(sc / ONE, SC_W));
		w.cr = CR_W'(sat_to((r * ONE + rc) / ONE, CR_W));
		w.cs = CS_W'(sat_to((s * ONE + sc) / ONE, CS_W));
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		fix_word_t got, want;
		int k;
		if (!arst_n) begin
			for (k = 0; k < 3; k++) begin
				knot_km[k] = '0;
				knot_pair[k] = '0;
			end
			range_acc = '0;
			second_acc = '0;
			due_q.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_REF_KM_1:    knot_km[0] = cfg_data[KM_W-1:0];
					REG_REF_KM_2:    knot_km[1] = cfg_data[KM_W-1:0];
					REG_REF_KM_3:    knot_km[2] = cfg_data[KM_W-1:0];
					REG_CORR_PAIR_1: knot_pair[0] = cfg_data;
					REG_CORR_PAIR_2: knot_pair[1] = cfg_data;
					REG_CORR_PAIR_3: knot_pair[2] = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				due_q.push_back(correct_word(measured_range, measured_second));
			end
			if (out_valid && out_ready) begin
				got = {range_corr, second_corr, corrected_range, corrected_second, held};
				if (due_q.size() == 0) begin
					if (mismatches < 10) begin
						$display("%0t: result word with nothing pending: rc=%0d sc=%0d cr=%0d cs=%0d held=%0b",
							$realtime, $signed(got.rc), $signed(got.sc), $signed(got.cr),
							$signed(got.cs), got.held);
					end
					mismatches++;
				end else begin
					want = due_q.pop_front();
					if (got.rc !== want.rc || got.sc !== want.sc || got.cr !== want.cr ||
						got.cs !== want.cs || got.held !== want.held) begin
						if (mismatches < 10) begin
							$display("%0t: expected rc=%0d sc=%0d cr=%0d cs=%0d held=%0b",
								$realtime, $signed(want.rc), $signed(want.sc), $signed(want.cr),
								$signed(want.cs), want.held);
							$display("%0t:      got rc=%0d sc=%0d cr=%0d cs=%0d held=%0b",
								$realtime, $signed(got.rc), $signed(got.sc), $signed(got.cr),
								$signed(got.cs), got.held);
						end
						mismatches++;
					end
				end
			end
			outstanding <= due_q.size();
		end
	end

endmodule

// File: test/tb_three_knot_range_correction.sv
// tb_three_knot_range_correction: drives knot settings and measurement words
// into the block with random gaps and stalls, and gives the verdict.
// Depends on tkrc_pkg, three_knot_range_correction and range_fix_checker.
module tb_three_knot_range_correction import tkrc_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [RANGE_W-1:0] RANGE_MAX = '1;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [CFG_IDX_W-1:0]       cfg_idx;
	logic [PAIR_W-1:0]          cfg_data;
	logic                       in_valid;
	logic                       in_ready;
	logic [RANGE_W-1:0]         measured_range;
	logic signed [SECOND_W-1:0] measured_second;
	logic                       out_valid;
	logic                       out_ready;
	logic signed [RC_W-1:0]     range_corr;
	logic signed [SC_W-1:0]     second_corr;
	logic signed [CR_W-1:0]     corrected_range;
	logic signed [CS_W-1:0]     corrected_second;
	logic                       held;
	int                         mismatch_total;
	int                         words_in_flight;

	// current knot setting, kept only to aim ranges at the knots
	logic [KM_W-1:0]   km_set [3];
	logic [PAIR_W-1:0] pair_set [3];
	bit                tx_fast;

	three_knot_range_correction DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_idx          (cfg_idx),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.measured_range   (measured_range),
		.measured_second  (measured_second),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.range_corr       (range_corr),
		.second_corr      (second_corr),
		.corrected_range  (corrected_range),
		.corrected_second (corrected_second),
		.held             (held)
	);

	range_fix_checker fix_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_idx          (cfg_idx),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.measured_range   (measured_range),
		.measured_second  (measured_second),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.range_corr       (range_corr),
		.second_corr      (second_corr),
		.corrected_range  (corrected_range),
		.corrected_second (corrected_second),
		.held             (held),
		.mismatches       (mismatch_total),
		.outstanding      (words_in_flight)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// keeps cfg_we high; the caller lowers it after the last beat
	task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [PAIR_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic load_knots(input logic [KM_W-1:0] k1, input logic [KM_W-1:0] k2,
		input logic [KM_W-1:0] k3, input logic [PAIR_W-1:0] p1,
		input logic [PAIR_W-1:0] p2, input logic [PAIR_W-1:0] p3);
		km_set[0] = k1;
		km_set[1] = k2;
		km_set[2] = k3;
		pair_set[0] = p1;
		pair_set[1] = p2;
		pair_set[2] = p3;
		cfg_beat(REG_REF_KM_1, {{(PAIR_W-KM_W){1'b0}}, k1});
		cfg_beat(REG_REF_KM_2, {{(PAIR_W-KM_W){1'b0}}, k2});
		cfg_beat(REG_REF_KM_3, {{(PAIR_W-KM_W){1'b0}}, k3});
		cfg_beat(REG_CORR_PAIR_1, p1);
		cfg_beat(REG_CORR_PAIR_2, p2);
		cfg_beat(REG_CORR_PAIR_3, p3);
		cfg_we <= 1'b0;
	endtask

	// returns at the edge that accepted the word, valid still high
	task automatic push_word(input logic [RANGE_W-1:0] r, input logic signed [SECOND_W-1:0] s);
		int gap;
		gap = tx_fast ? 0 : int'($urandom_range(0, 4));
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		measured_range <= r;
		measured_second <= s;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (words_in_flight != 0) @(posedge clk);
	endtask

	function automatic logic [RANGE_W-1:0] pick_range();
		longint v;
		int k;
		k = int'($urandom_range(0, 2));
		case ($urandom_range(0, 9))
			0: v = 0;
			1: v = longint'(RANGE_MAX);
			2, 3: v = longint'($urandom_range(0, int'(RANGE_MAX)));
			default: begin
				v = longint'(km_set[k]) * KM_SCALE - longint'($signed(pair_set[k][PAIR_W-1 -: CORR_W]))
					+ longint'($urandom_range(0, 4000)) - 2000;
			end
		endcase
		if (v < 0) begin
			v = 0;
		end else if (v > longint'(RANGE_MAX)) begin
			v = longint'(RANGE_MAX);
		end
		return v[RANGE_W-1:0];
	endfunction

	task automatic random_knots();
		logic [KM_W-1:0]   k [3];
		logic [PAIR_W-1:0] p [3];
		int i, rc;
		for (i = 0; i < 3; i++) begin
			p[i] = $urandom;
			// small range corrections keep the knots in order more often
			if ($urandom_range(0, 2) != 0) begin
				rc = int'($urandom_range(0, 1000)) - 500;
				p[i][PAIR_W-1 -: CORR_W] = rc[CORR_W-1:0];
			end
			if (i == 0) begin
				k[i] = KM_W'($urandom);
			end else begin
				case ($urandom_range(0, 5))
					0: begin
						// coincident knot, zero span
						k[i] = k[i-1];
						p[i][PAIR_W-1 -: CORR_W] = p[i-1][PAIR_W-1 -: CORR_W];
					end
					1: k[i] = KM_W'($urandom);
					default: k[i] = KM_W'(k[i-1] + $urandom_range(1, 30));
				endcase
			end
		end
		load_knots(k[0], k[1], k[2], p[0], p[1], p[2]);
	endtask

	initial begin
		int phase, n;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= REG_REF_KM_1;
		cfg_data <= '0;
		in_valid <= 1'b0;
		measured_range <= '0;
		measured_second <= '0;
		tx_fast = 1'b0;
		for (n = 0; n < 3; n++) begin
			km_set[n] = '0;
			pair_set[n] = '0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset knots all sit at zero: every word is held at zero correction
		push_word('0, 16'sh8000);
		push_word(RANGE_MAX, 16'sh7fff);
		push_word(18'd1, 16'sh0000);

		// ordinary knots, hit each knot, between, and beyond both ends
		drain();
		load_knots(8'd10, 8'd20, 8'd30, 32'h0005_0064, 32'hfffb_ff38, 32'h000a_012c);
		push_word(18'd9995, 16'sh8000);
		push_word(18'd20005, 16'sh7fff);
		push_word(18'd29990, SECOND_W'($urandom));
		push_word('0, 16'sh7fff);
		push_word(18'd15000, SECOND_W'($urandom));
		push_word(18'd25000, SECOND_W'($urandom));
		push_word(RANGE_MAX, 16'sh8000);
		push_word(18'd20006, SECOND_W'($urandom));

		// span of one metre with extreme corrections: stored value saturates
		drain();
		load_knots(8'd255, 8'd255, 8'd255, 32'h8000_8000, 32'h8001_7fff, 32'h7fff_ffff);
		push_word('0, 16'sh8000);
		push_word(18'd131072, SECOND_W'($urandom));
		push_word(RANGE_MAX, 16'sh7fff);

		// knots two and three coincide: past knot two the last value is held
		drain();
		load_knots(8'd1, 8'd2, 8'd2, 32'h0000_1234, 32'h0000_8000, 32'h0000_7fff);
		push_word(18'd1500, SECOND_W'($urandom));
		push_word(18'd3000, SECOND_W'($urandom));
		push_word(RANGE_MAX, 16'sh8000);
		push_word(18'd2000, SECOND_W'($urandom));
		push_word('0, 16'sh7fff);

		// all three knots coincide
		drain();
		load_knots(8'd7, 8'd7, 8'd7, 32'h0010_0000, 32'h0010_0000, 32'h0010_0000);
		push_word(18'd5000, SECOND_W'($urandom));
		push_word(18'd123, 16'sh8000);

		// first span empty, second span always used
		drain();
		load_knots(8'd4, 8'd4, 8'd9, 32'hffff_ffff, 32'hffff_0001, 32'h7fff_8000);
		push_word('0, SECOND_W'($urandom));
		push_word(18'd4000, SECOND_W'($urandom));
		push_word(RANGE_MAX, SECOND_W'($urandom));

		for (phase = 0; phase < 12; phase++) begin
			drain();
			random_knots();
			tx_fast = ($urandom_range(0, 3) == 0);
			for (n = 0; n < 160; n++) begin
				push_word(pick_range(), SECOND_W'($urandom));
			end
		end

		drain();
		repeat (50) @(posedge clk);
		if (mismatch_total == 0 && words_in_flight == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// result side: random stalls, fast stretches, and two long hold-offs
	initial begin
		int stall, got;
		bit fast;
		out_ready <= 1'b0;
		got = 0;
		fast = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (got % 100 == 0) begin
				fast = ($urandom_range(0, 3) == 0);
			end
			if (got == 300 || got == 1200) begin
				stall = 600;
			end else begin
				stall = fast ? 0 : int'($urandom_range(0, 4));
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			got++;
		end
	end

	initial begin
		#10_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
